[hw/rtl/pra_pkg.sv]
// shared constants, beat types and ring index helper for the page range allocator
package pra_pkg;

  localparam int unsigned PAGE_BITS  = 12;
  localparam int unsigned MAX_RANGES = 16;

  localparam int unsigned PG_W  = 32 - PAGE_BITS;
  localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned ENT_W = 2 * PG_W;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RAISE = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [31:0] length_bytes;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic        status;
  } rsp_t;

  // one ring entry, both fields in pages
  typedef struct packed {
    logic [PG_W-1:0] start;
    logic [PG_W-1:0] size;
  } ring_entry_t;

  // (head + off) modulo the ring depth, off never above the depth
  function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(MAX_RANGES)) begin
      sum = sum - (CNT_W + 1)'(MAX_RANGES);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

[hw/rtl/pra_ram.sv]
// generic single write port ram with registered read
module pra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/page_range_allocator.sv]
// page range allocator: free range ring with first fit scan and bump pointer
//
// usage
// - command beat on req_i is taken at a clock edge with start_i high and busy_o low;
//   busy_o then stays high until the result is out
// - every command gives exactly one result beat on rsp_o, shown for one cycle with
//   done_o high; the receiver cannot stall it, so it must take it in that cycle
// - allocate rounds the length up to a page, scans the ring from its head rotating
//   misses to the tail, carves the first range that fits, else bumps the top pointer
// - free merges into the first neighbor found below or above, else appends; a full
//   ring drops the range and reports status 1
// - raise lifts the top pointer to the page-rounded bound when the bound lies above it
// sequence
// - one shared add/subtract unit, one ring entry read per cycle from a registered ram
// - allocate/free scan the ring, then end in the update state on a fit or merge, in the
//   top state when an allocate falls through, or in the scan on a free append; raise: top state
// - done_o rises as busy_o falls; a new command can be taken while done_o is high
// reset
// - asynchronous, active low: ring empty, head and top pointer zero; the ring ram
//   itself is not cleared, only entries below the fill count are ever used
module page_range_allocator
  import pra_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_TOP  = 2'd3;

  // control state
  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PG_W-1:0]  top_q, top_d;
  logic [CNT_W-1:0] visit_q, visit_d;
  logic             done_q, done_d;

  // per command payload
  logic [1:0]       op_q, op_d;
  logic [PG_W-1:0]  a_q, a_d;          // freed start, pages
  logic [PG_W-1:0]  s_q, s_d;          // freed size, pages
  logic [PG_W-1:0]  sum_q, sum_d;      // need, bound, or end of freed range
  ring_entry_t      ent_q, ent_d;
  logic [PG_W-1:0]  diff_q, diff_d;
  logic             merge_hi_q, merge_hi_d;
  logic [IDX_W-1:0] wslot_q, wslot_d;
  rsp_t             rsp_q, rsp_d;

  // ring ram
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  ring_entry_t      ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  ring_entry_t      rd_ent;

  // shared adder / subtractor
  logic [PG_W-1:0] unit_a, unit_b;
  logic            unit_sub, unit_cin;
  logic [PG_W:0]   unit_res;
  logic            unit_co;
  logic [PG_W-1:0] unit_sum;

  logic             accept;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail_slot;
  logic             scan_end;

  assign accept    = start_i && (state_q == S_IDLE);
  assign rd_ent    = ring_entry_t'(ram_rdata);
  assign head_next = ring_slot(head_q, CNT_W'(1));
  assign tail_slot = ring_slot(head_q, count_q);
  assign scan_end  = (visit_q == count_q);

  // entry at the head is read ahead: head while idle, next head while scanning
  assign ram_raddr = (state_q == S_IDLE) ? head_q : head_next;

  pra_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_RANGES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ENT_W'(ram_wdata)),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // operand select for the shared unit
  always_comb begin
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b0;
    unit_cin = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.operation == OP_FREE) begin
          unit_a = req_i.address[31:PAGE_BITS];
          unit_b = req_i.length_bytes[31:PAGE_BITS];
        end else if (req_i.operation == OP_ALLOC) begin
          unit_a   = req_i.length_bytes[31:PAGE_BITS];
          unit_cin = |req_i.length_bytes[PAGE_BITS-1:0];
        end else begin
          unit_a   = req_i.address[31:PAGE_BITS];
          unit_cin = |req_i.address[PAGE_BITS-1:0];
        end
      end
      S_SCAN: begin
        if (op_q == OP_ALLOC) begin
          unit_a   = rd_ent.size;
          unit_b   = sum_q;
          unit_sub = 1'b1;
        end else begin
          unit_a = rd_ent.start;
          unit_b = rd_ent.size;
        end
      end
      S_UPD: begin
        if (op_q == OP_ALLOC) begin
          unit_a = ent_q.start;
          unit_b = sum_q;
        end else begin
          unit_a = ent_q.size;
          unit_b = s_q;
        end
      end
      S_TOP: begin
        unit_a   = top_q;
        unit_b   = sum_q;
        unit_sub = (op_q == OP_RAISE);
      end
      default: begin
        unit_a = '0;
      end
    endcase
  end

  assign unit_res = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                  + (PG_W + 1)'(unit_sub | unit_cin);
  assign unit_co  = unit_res[PG_W];
  assign unit_sum = unit_res[PG_W-1:0];

  // sequencer
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    top_d      = top_q;
    visit_d    = visit_q;
    done_d     = 1'b0;
    op_d       = op_q;
    a_d        = a_q;
    s_d        = s_q;
    sum_d      = sum_q;
    ent_d      = ent_q;
    diff_d     = diff_q;
    merge_hi_d = merge_hi_q;
    wslot_d    = wslot_q;
    rsp_d      = rsp_q;
    ram_we     = 1'b0;
    ram_waddr  = tail_slot;
    ram_wdata  = rd_ent;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = req_i.operation;
          a_d     = req_i.address[31:PAGE_BITS];
          s_d     = req_i.length_bytes[31:PAGE_BITS];
          sum_d   = unit_sum;
          visit_d = '0;
          if (req_i.operation inside {OP_ALLOC, OP_FREE}) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_TOP;
          end
        end
      end

      S_SCAN: begin
        if (scan_end) begin
          if (op_q == OP_ALLOC) begin
            state_d = S_TOP;
          end else begin
            // no neighbor: append, or drop when the ring is full
            state_d = S_IDLE;
            done_d  = 1'b1;
            rsp_d   = '{granted_address: '0, status: STATUS_OK};
            if (count_q >= CNT_W'(MAX_RANGES)) begin
              rsp_d.status = STATUS_DROPPED;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = '{start: a_q, size: s_q};
              count_d   = count_q + CNT_W'(1);
            end
          end
        end else if (op_q == OP_ALLOC && unit_co) begin
          // first fit at the head
          ent_d   = rd_ent;
          diff_d  = unit_sum;
          state_d = S_UPD;
        end else begin
          // rotate head entry to the tail
          ram_we  = 1'b1;
          head_d  = head_next;
          visit_d = visit_q + CNT_W'(1);
          wslot_d = tail_slot;
          if (op_q == OP_FREE) begin
            if (unit_sum == a_q) begin
              ent_d      = rd_ent;
              merge_hi_d = 1'b0;
              state_d    = S_UPD;
            end else if (sum_q == rd_ent.start) begin
              ent_d      = rd_ent;
              merge_hi_d = 1'b1;
              state_d    = S_UPD;
            end
          end
        end
      end

      S_UPD: begin
        ram_we  = 1'b1;
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (op_q == OP_ALLOC) begin
          ram_waddr = head_q;
          ram_wdata = '{start: unit_sum, size: diff_q};
          rsp_d     = '{granted_address: {ent_q.start, {PAGE_BITS{1'b0}}},
                        status: STATUS_OK};
          if (diff_q == '0) begin
            head_d  = head_next;
            count_d = count_q - CNT_W'(1);
          end
        end else begin
          ram_waddr = wslot_q;
          ram_wdata = '{start: (merge_hi_q ? a_q : ent_q.start), size: unit_sum};
          rsp_d     = '{granted_address: '0, status: STATUS_OK};
        end
      end

      S_TOP: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        rsp_d   = '{granted_address: '0, status: STATUS_OK};
        case (op_q)
          OP_ALLOC: begin
            top_d                 = unit_sum;
            rsp_d.granted_address = {top_q, {PAGE_BITS{1'b0}}};
          end
          OP_RAISE: begin
            // borrow means bound above top
            if (!unit_co) begin
              top_d = sum_q;
            end
          end
          default: begin
            top_d = top_q;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      top_q   <= '0;
      visit_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      top_q   <= top_d;
      visit_q <= visit_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    a_q        <= a_d;
    s_q        <= s_d;
    sum_q      <= sum_d;
    ent_q      <= ent_d;
    diff_q     <= diff_d;
    merge_hi_q <= merge_hi_d;
    wslot_q    <= wslot_d;
    rsp_q      <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // fill count never passes the ring depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RANGES))
    else $error("ring fill count above depth");

  // head stays inside the ring
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(head_q) < CNT_W'(MAX_RANGES))
    else $error("ring head out of range");

  // a taken command always goes busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted command did not start");

  // result beat only once the block has gone idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result beat without a finished command");

  // a dropped free only happens with a full ring
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status |-> count_q == CNT_W'(MAX_RANGES))
    else $error("free dropped while ring had room");

  // scan never visits more entries than the ring holds
  a_visit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> visit_q <= count_q)
    else $error("scan ran past ring fill");

endmodule
